[hdl/tci_pkg.sv]
// Shared constants for the trilinear cell interpolator.
package tci_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int NUM_CORNERS     = 8;
	localparam int NUM_STAGES      = 11;

endpackage

[hdl/tci_in_if.sv]
// Input channel: eight corner samples and one local point per word.
interface tci_in_if #(
	parameter int SAMPLE_BITS = tci_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = tci_pkg::FRAC_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] corner_0;
	logic signed [SAMPLE_BITS-1:0] corner_1;
	logic signed [SAMPLE_BITS-1:0] corner_2;
	logic signed [SAMPLE_BITS-1:0] corner_3;
	logic signed [SAMPLE_BITS-1:0] corner_4;
	logic signed [SAMPLE_BITS-1:0] corner_5;
	logic signed [SAMPLE_BITS-1:0] corner_6;
	logic signed [SAMPLE_BITS-1:0] corner_7;
	logic        [FRAC_BITS:0]     pos_p;
	logic        [FRAC_BITS:0]     pos_q;
	logic        [FRAC_BITS:0]     pos_r;

	modport source (
		output valid, corner_0, corner_1, corner_2, corner_3,
		output corner_4, corner_5, corner_6, corner_7, pos_p, pos_q, pos_r,
		input  ready
	);
	modport sink (
		input  valid, corner_0, corner_1, corner_2, corner_3,
		input  corner_4, corner_5, corner_6, corner_7, pos_p, pos_q, pos_r,
		output ready
	);
endinterface

[hdl/tci_out_if.sv]
// Output channel: interpolated value and negated local gradient per word.
interface tci_out_if #(
	parameter int SAMPLE_BITS = tci_pkg::SAMPLE_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic signed [SAMPLE_BITS-1:0] interp_value;
	logic signed [SAMPLE_BITS:0]   neg_grad_p;
	logic signed [SAMPLE_BITS:0]   neg_grad_q;
	logic signed [SAMPLE_BITS:0]   neg_grad_r;

	modport source (
		output valid, interp_value, neg_grad_p, neg_grad_q, neg_grad_r,
		input  ready
	);
	modport sink (
		input  valid, interp_value, neg_grad_p, neg_grad_q, neg_grad_r,
		output ready
	);
endinterface

[hdl/tci_lane.sv]
// Exact linear interpolation lane: y = a*ONE + (b-a)*t, three pipeline stages.
module tci_lane #(
	parameter int W = 16,
	parameter int F = 16
) (
	input  logic                  clk,
	input  logic [2:0]            ce,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	input  logic        [F:0]     t,
	output logic signed [W+F-1:0] y
);
	localparam int DW = W + 1;
	localparam int H  = DW / 2;
	localparam int HW = DW - H;
	localparam int LW = H + F + 1;
	localparam int PW = HW + F + 2;
	localparam int SW = W + F + 2;

	logic signed [W-1:0]   a_s1;
	logic signed [W-1:0]   a_s2;
	logic signed [DW-1:0]  d_s1;
	logic        [F:0]     t_s1;
	logic        [LW-1:0]  plo_s2;
	logic signed [PW-1:0]  phi_s2;
	logic signed [W+F-1:0] y_s3;
	logic        [SW-1:0]  sum;

	// split product: low half unsigned, high half signed
	always_ff @(posedge clk) begin
		if (ce[0]) begin
			a_s1 <= a;
			d_s1 <= DW'(b) - DW'(a);
			t_s1 <= t;
		end
		if (ce[1]) begin
			a_s2   <= a_s1;
			plo_s2 <= LW'(d_s1[H-1:0]) * LW'(t_s1);
			phi_s2 <= PW'($signed(d_s1[DW-1:H])) * PW'($signed({1'b0, t_s1}));
		end
		if (ce[2]) begin
			y_s3 <= $signed(sum[W+F-1:0]);
		end
	end

	assign sum = (SW'(a_s2) <<< F) + (SW'(phi_s2) <<< H) + SW'(plo_s2);
	assign y   = y_s3;
endmodule

[hdl/tci_merge.sv]
// Merge stage: rounds lane results and aligns them into the output register.
module tci_merge #(
	parameter int S = 16,
	parameter int F = 16
) (
	input  logic                    clk,
	input  logic [3:0]              ce,
	input  logic signed [S+3*F-1:0] val_raw,
	input  logic signed [S+2*F:0]   gp_raw,
	input  logic signed [S+2*F:0]   gq_raw,
	input  logic signed [S+2*F:0]   gr_raw,
	output logic signed [S-1:0]     interp_value,
	output logic signed [S:0]       neg_grad_p,
	output logic signed [S:0]       neg_grad_q,
	output logic signed [S:0]       neg_grad_r
);
	localparam int VW = S + 3 * F;
	localparam int GW = S + 2 * F + 1;
	localparam logic [VW-1:0] VHALF = VW'(1) << (3 * F - 1);
	localparam logic [GW-1:0] GHALF = GW'(1) << (2 * F - 1);

	logic [VW-1:0] val_rnd;
	logic [GW-1:0] gp_rnd, gq_rnd, gr_rnd;
	logic signed [S:0] gp_s8, gp_s9, gp_s10, gp_s11;
	logic signed [S:0] gq_s8, gq_s9, gq_s10, gq_s11;
	logic signed [S:0] gr_s8, gr_s9, gr_s10, gr_s11;
	logic signed [S-1:0] val_s11;

	// round half up: add half, keep the integer bits
	assign val_rnd = val_raw + VHALF;
	assign gp_rnd  = gp_raw + GHALF;
	assign gq_rnd  = gq_raw + GHALF;
	assign gr_rnd  = gr_raw + GHALF;

	always_ff @(posedge clk) begin
		if (ce[0]) begin
			gp_s8 <= $signed(gp_rnd[2*F +: S+1]);
			gq_s8 <= $signed(gq_rnd[2*F +: S+1]);
			gr_s8 <= $signed(gr_rnd[2*F +: S+1]);
		end
		if (ce[1]) begin
			gp_s9 <= gp_s8;
			gq_s9 <= gq_s8;
			gr_s9 <= gr_s8;
		end
		if (ce[2]) begin
			gp_s10 <= gp_s9;
			gq_s10 <= gq_s9;
			gr_s10 <= gr_s9;
		end
		if (ce[3]) begin
			gp_s11  <= gp_s10;
			gq_s11  <= gq_s10;
			gr_s11  <= gr_s10;
			val_s11 <= $signed(val_rnd[3*F +: S]);
		end
	end

	assign interp_value = val_s11;
	assign neg_grad_p   = gp_s11;
	assign neg_grad_q   = gq_s11;
	assign neg_grad_r   = gr_s11;
endmodule

[hdl/trilinear_cell_interpolator.sv]
// Trilinear cell interpolator top level: value and negated gradient per cell.
// Output valid is the registered valid flag of the last stage.
// Throughput: one word per cycle; each stage stalls only when the next is full.
// Depth is set by three chained lerp levels plus input and rounding stages.
// Reset clears only the stage valid flags; data registers are not reset.
module trilinear_cell_interpolator #(
	parameter int SAMPLE_BITS = tci_pkg::SAMPLE_BITS_DEF,
	parameter int FRAC_BITS   = tci_pkg::FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tci_in_if.sink    in_word,
	tci_out_if.source out_word
);
	import tci_pkg::*;

	localparam int S  = SAMPLE_BITS;
	localparam int F  = FRAC_BITS;
	localparam int SD = S + 1;
	localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES:1] vld_d;
	logic [NUM_STAGES:1] ce;

	logic signed [S-1:0]  c_s1 [NUM_CORNERS];
	logic signed [SD-1:0] dp_s1 [4];
	logic signed [SD-1:0] dq_s1 [4];
	logic signed [SD-1:0] dr_s1 [4];
	logic [F:0] p_s1;
	logic [F:0] q_s1, q_s2, q_s3, q_s4;
	logic [F:0] r_s1, r_s2, r_s3, r_s4, r_s5, r_s6, r_s7;

	logic signed [S+F-1:0]    vx_s4 [4];
	logic signed [S+2*F-1:0]  vy_s7 [2];
	logic signed [S+3*F-1:0]  vz_s10;
	logic signed [SD+F-1:0]   gp_s4 [2];
	logic signed [SD+F-1:0]   gq_s4 [2];
	logic signed [SD+F-1:0]   gr_s4 [2];
	logic signed [SD+2*F-1:0] gp_s7, gq_s7, gr_s7;

	// per-stage load enables, bubbles collapse
	always_comb begin
		ce[NUM_STAGES] = !vld_q[NUM_STAGES] || out_word.ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			ce[k] = !vld_q[k] || ce[k+1];
		end
	end

	assign vld_d = {vld_q[NUM_STAGES-1:1], in_word.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~ce) | (vld_d & ce);
		end
	end

	assign in_word.ready  = ce[1];
	assign out_word.valid = vld_q[NUM_STAGES];

	// input stage: clamp coordinates, corner differences for the gradients
	always_ff @(posedge clk) begin
		if (ce[1]) begin
			c_s1[0] <= in_word.corner_0;
			c_s1[1] <= in_word.corner_1;
			c_s1[2] <= in_word.corner_2;
			c_s1[3] <= in_word.corner_3;
			c_s1[4] <= in_word.corner_4;
			c_s1[5] <= in_word.corner_5;
			c_s1[6] <= in_word.corner_6;
			c_s1[7] <= in_word.corner_7;
			dp_s1[0] <= SD'(in_word.corner_0) - SD'(in_word.corner_1);
			dp_s1[1] <= SD'(in_word.corner_3) - SD'(in_word.corner_2);
			dp_s1[2] <= SD'(in_word.corner_4) - SD'(in_word.corner_5);
			dp_s1[3] <= SD'(in_word.corner_7) - SD'(in_word.corner_6);
			dq_s1[0] <= SD'(in_word.corner_0) - SD'(in_word.corner_3);
			dq_s1[1] <= SD'(in_word.corner_1) - SD'(in_word.corner_2);
			dq_s1[2] <= SD'(in_word.corner_4) - SD'(in_word.corner_7);
			dq_s1[3] <= SD'(in_word.corner_5) - SD'(in_word.corner_6);
			dr_s1[0] <= SD'(in_word.corner_0) - SD'(in_word.corner_4);
			dr_s1[1] <= SD'(in_word.corner_1) - SD'(in_word.corner_5);
			dr_s1[2] <= SD'(in_word.corner_3) - SD'(in_word.corner_7);
			dr_s1[3] <= SD'(in_word.corner_2) - SD'(in_word.corner_6);
			p_s1 <= (in_word.pos_p > ONE) ? ONE : in_word.pos_p;
			q_s1 <= (in_word.pos_q > ONE) ? ONE : in_word.pos_q;
			r_s1 <= (in_word.pos_r > ONE) ? ONE : in_word.pos_r;
		end
		if (ce[2]) begin
			q_s2 <= q_s1;
			r_s2 <= r_s1;
		end
		if (ce[3]) begin
			q_s3 <= q_s2;
			r_s3 <= r_s2;
		end
		if (ce[4]) begin
			q_s4 <= q_s3;
			r_s4 <= r_s3;
		end
		if (ce[5]) begin
			r_s5 <= r_s4;
		end
		if (ce[6]) begin
			r_s6 <= r_s5;
		end
		if (ce[7]) begin
			r_s7 <= r_s6;
		end
	end

	// value: lerp along p, then q, then r
	tci_lane #(.W(S), .F(F)) u_vx0 (.clk(clk), .ce(ce[4:2]),
		.a(c_s1[0]), .b(c_s1[1]), .t(p_s1), .y(vx_s4[0]));
	tci_lane #(.W(S), .F(F)) u_vx1 (.clk(clk), .ce(ce[4:2]),
		.a(c_s1[3]), .b(c_s1[2]), .t(p_s1), .y(vx_s4[1]));
	tci_lane #(.W(S), .F(F)) u_vx2 (.clk(clk), .ce(ce[4:2]),
		.a(c_s1[4]), .b(c_s1[5]), .t(p_s1), .y(vx_s4[2]));
	tci_lane #(.W(S), .F(F)) u_vx3 (.clk(clk), .ce(ce[4:2]),
		.a(c_s1[7]), .b(c_s1[6]), .t(p_s1), .y(vx_s4[3]));
	tci_lane #(.W(S+F), .F(F)) u_vy0 (.clk(clk), .ce(ce[7:5]),
		.a(vx_s4[0]), .b(vx_s4[1]), .t(q_s4), .y(vy_s7[0]));
	tci_lane #(.W(S+F), .F(F)) u_vy1 (.clk(clk), .ce(ce[7:5]),
		.a(vx_s4[2]), .b(vx_s4[3]), .t(q_s4), .y(vy_s7[1]));
	tci_lane #(.W(S+2*F), .F(F)) u_vz (.clk(clk), .ce(ce[10:8]),
		.a(vy_s7[0]), .b(vy_s7[1]), .t(r_s7), .y(vz_s10));

	// gradient along p: differences in x, lerp along q then r
	tci_lane #(.W(SD), .F(F)) u_gp0 (.clk(clk), .ce(ce[4:2]),
		.a(dp_s1[0]), .b(dp_s1[1]), .t(q_s1), .y(gp_s4[0]));
	tci_lane #(.W(SD), .F(F)) u_gp1 (.clk(clk), .ce(ce[4:2]),
		.a(dp_s1[2]), .b(dp_s1[3]), .t(q_s1), .y(gp_s4[1]));
	tci_lane #(.W(SD+F), .F(F)) u_gp (.clk(clk), .ce(ce[7:5]),
		.a(gp_s4[0]), .b(gp_s4[1]), .t(r_s4), .y(gp_s7));

	// gradient along q: differences in y, lerp along p then r
	tci_lane #(.W(SD), .F(F)) u_gq0 (.clk(clk), .ce(ce[4:2]),
		.a(dq_s1[0]), .b(dq_s1[1]), .t(p_s1), .y(gq_s4[0]));
	tci_lane #(.W(SD), .F(F)) u_gq1 (.clk(clk), .ce(ce[4:2]),
		.a(dq_s1[2]), .b(dq_s1[3]), .t(p_s1), .y(gq_s4[1]));
	tci_lane #(.W(SD+F), .F(F)) u_gq (.clk(clk), .ce(ce[7:5]),
		.a(gq_s4[0]), .b(gq_s4[1]), .t(r_s4), .y(gq_s7));

	// gradient along r: differences in z, lerp along p then q
	tci_lane #(.W(SD), .F(F)) u_gr0 (.clk(clk), .ce(ce[4:2]),
		.a(dr_s1[0]), .b(dr_s1[1]), .t(p_s1), .y(gr_s4[0]));
	tci_lane #(.W(SD), .F(F)) u_gr1 (.clk(clk), .ce(ce[4:2]),
		.a(dr_s1[2]), .b(dr_s1[3]), .t(p_s1), .y(gr_s4[1]));
	tci_lane #(.W(SD+F), .F(F)) u_gr (.clk(clk), .ce(ce[7:5]),
		.a(gr_s4[0]), .b(gr_s4[1]), .t(q_s4), .y(gr_s7));

	tci_merge #(.S(S), .F(F)) u_merge (
		.clk          (clk),
		.ce           (ce[NUM_STAGES:NUM_STAGES-3]),
		.val_raw      (vz_s10),
		.gp_raw       (gp_s7),
		.gq_raw       (gq_s7),
		.gr_raw       (gr_s7),
		.interp_value (out_word.interp_value),
		.neg_grad_p   (out_word.neg_grad_p),
		.neg_grad_q   (out_word.neg_grad_q),
		.neg_grad_r   (out_word.neg_grad_r)
	);
endmodule
